@@ hdl/rgb_led_string_serializer_macros.svh @@
// ----------------------------------------------------------------------------
// RGB LED string serializer assertion macros
// Concurrent assertion shorthands, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_STRING_SERIALIZER_MACROS_SVH
`define RGB_LED_STRING_SERIALIZER_MACROS_SVH

// condition holds at every edge
`define RLS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define RLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rls_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB LED string serializer package
// Item codes, register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package rls_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SET     = 2'd1,
    FUNC_REFRESH = 2'd2,
    FUNC_TICK_X  = 2'd3
  } func_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd4;

  localparam int TICK_W  = 8;
  localparam int RSLOT_W = 10;
  localparam int LCNT_W  = 11;
  localparam int SLOT_W  = 15;
  localparam int COLOR_W = 24;
  localparam int INDEX_W = 8;

  localparam logic [TICK_W-1:0]  SLOT_LEN_RST    = 8'd78;
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST    = 8'd42;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST   = 8'd21;
  localparam logic [RSLOT_W-1:0] RESET_SLOTS_RST = 10'd50;
  localparam logic [LCNT_W-1:0]  LED_COUNT_RST   = 11'd16;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2**16
  localparam int DIV3_MUL   = 43691;
  localparam int DIV3_SHIFT = 17;

endpackage

@@ hdl/rgb_led_string_serializer.sv @@
// ----------------------------------------------------------------------------
// RGB LED string serializer
// Stores one color per LED and produces the one-wire line waveform, one tick
// item per transfer.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: func[1:0]; tdata: led_index[7:0], color[31:8]
//  m_*      | out       | tdata: line_level[0], busy_res[1], write_ignored[2]
//  cfg_*    | in        | register write: cfg_index selects, cfg_data[10:0]
//
//  One transfer in per clock unless stalled, result in the output register
//  in the cycle after the transfer. The path is set by the slot-to-LED split
//  (one constant multiply) and the color store read.
//  The input side stalls only while a result waits and m_tready is low.
//  rst is synchronous; it restores register defaults and clears all colors.
// ----------------------------------------------------------------------------
`include "rgb_led_string_serializer_macros.svh"

module rgb_led_string_serializer
  import rls_pkg::*;
#(
  parameter int MAX_LEDS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // led_index[7:0], color[31:8]
  input  logic [1:0]            s_tuser,   // func[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // line_level[0], busy_res[1], write_ignored[2]
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [LCNT_W-1:0] LED_LIMIT = LCNT_W'(MAX_LEDS);

  // configuration
  logic [TICK_W-1:0]  slot_len;
  logic [TICK_W-1:0]  one_high;
  logic [TICK_W-1:0]  zero_high;
  logic [RSLOT_W-1:0] reset_slots;
  logic [LCNT_W-1:0]  led_count;

  // frame state
  logic [COLOR_W-1:0] color_store [MAX_LEDS];
  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic [TICK_W-1:0]  tick_in_slot, tick_in_slot_next;
  logic               sending, sending_next;
  logic [2:0]         res, res_next;

  // input fields
  func_t              func;
  logic [INDEX_W-1:0] led_index;
  logic [COLOR_W-1:0] color;
  logic [LCNT_W-1:0]  idx_ext;
  logic               accept;
  logic               idx_ok;

  // slot decode
  logic [LCNT_W-1:0]  n_eff;
  logic [SLOT_W:0]    total;
  logic               slot_done;
  logic               in_data;
  logic [SLOT_W-1:0]  bofs;
  logic [27:0]        prod;
  logic [LCNT_W-1:0]  led_q;
  logic [SLOT_W-1:0]  led24;
  logic [SLOT_W-1:0]  pos_full;
  logic [4:0]         pos;
  logic               led_ok;
  logic [COLOR_W-1:0] cur_color;
  logic [COLOR_W-1:0] grb;
  logic               cur_bit;
  logic [TICK_W-1:0]  high_ticks;
  logic [TICK_W-1:0]  period;
  logic [TICK_W-1:0]  tick_inc;
  logic [SLOT_W-1:0]  slot_inc;
  logic               level;

  // checker terms
  logic               at_start;
  logic               acc_refresh;
  logic               acc_tick;

  assign func      = func_t'(s_tuser);
  assign led_index = s_tdata[7:0];
  assign color     = s_tdata[31:8];
  assign idx_ext   = LCNT_W'(led_index);
  assign idx_ok    = idx_ext < LED_LIMIT;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {5'd0, res};

  assign n_eff     = (led_count > LED_LIMIT) ? LED_LIMIT : led_count;
  assign total     = (SLOT_W+1)'(reset_slots) + (SLOT_W+1)'({n_eff, 4'b0})
                   + (SLOT_W+1)'({n_eff, 3'b0});
  assign slot_done = (SLOT_W+1)'(slot_index) >= total;
  assign in_data   = slot_index >= SLOT_W'(reset_slots);

  // LED = offset / 24, position = offset % 24
  assign bofs     = slot_index - SLOT_W'(reset_slots);
  assign prod     = 28'(bofs[SLOT_W-1:3]) * 28'(DIV3_MUL);
  assign led_q    = prod[DIV3_SHIFT +: LCNT_W];
  assign led24    = SLOT_W'({led_q, 4'b0}) + SLOT_W'({led_q, 3'b0});
  assign pos_full = bofs - led24;
  assign pos      = pos_full[4:0];
  assign led_ok   = led_q < LED_LIMIT;

  assign cur_color  = color_store[led_q[IDX_W-1:0]];
  assign grb        = {cur_color[15:8], cur_color[23:16], cur_color[7:0]};
  assign cur_bit    = grb[5'd23 - pos];
  assign high_ticks = (in_data && led_ok) ? (cur_bit ? one_high : zero_high) : '0;
  assign level      = tick_in_slot < high_ticks;

  assign period   = (slot_len == '0) ? TICK_W'(1) : slot_len;
  assign tick_inc = tick_in_slot + TICK_W'(1);
  assign slot_inc = slot_index + SLOT_W'(1);

  assign at_start    = (slot_index == '0) && (tick_in_slot == '0);
  assign acc_refresh = accept && (func == FUNC_REFRESH);
  assign acc_tick    = accept && ((func == FUNC_TICK) || (func == FUNC_TICK_X));

  always_comb begin
    slot_index_next   = slot_index;
    tick_in_slot_next = tick_in_slot;
    sending_next      = sending;
    res_next          = '0;
    case (func)
      FUNC_SET: begin
        res_next[2] = !idx_ok;
        res_next[1] = sending;
      end
      FUNC_REFRESH: begin
        sending_next      = 1'b1;
        slot_index_next   = '0;
        tick_in_slot_next = '0;
        res_next[1]       = 1'b1;
      end
      default: begin
        if (sending) begin
          if (slot_done) begin
            sending_next      = 1'b0;
            slot_index_next   = '0;
            tick_in_slot_next = '0;
          end else begin
            res_next[0] = level;
            res_next[1] = 1'b1;
            if (tick_inc >= period) begin
              tick_in_slot_next = '0;
              if ((SLOT_W+1)'(slot_inc) >= total) begin
                sending_next    = 1'b0;
                slot_index_next = '0;
              end else begin
                slot_index_next = slot_inc;
              end
            end else begin
              tick_in_slot_next = tick_inc;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_len     <= SLOT_LEN_RST;
      one_high     <= ONE_HIGH_RST;
      zero_high    <= ZERO_HIGH_RST;
      reset_slots  <= RESET_SLOTS_RST;
      led_count    <= LED_COUNT_RST;
      slot_index   <= '0;
      tick_in_slot <= '0;
      sending      <= 1'b0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < MAX_LEDS; i++) begin
        color_store[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SLOT_LEN:    slot_len    <= cfg_data[TICK_W-1:0];
          REG_ONE_HIGH:    one_high    <= cfg_data[TICK_W-1:0];
          REG_ZERO_HIGH:   zero_high   <= cfg_data[TICK_W-1:0];
          REG_RESET_SLOTS: reset_slots <= cfg_data[RSLOT_W-1:0];
          REG_LED_COUNT:   led_count   <= cfg_data[LCNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        slot_index   <= slot_index_next;
        tick_in_slot <= tick_in_slot_next;
        sending      <= sending_next;
        if (func == FUNC_SET && idx_ok) begin
          color_store[idx_ext[IDX_W-1:0]] <= color;
        end
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  `RLS_ASSERT_IMP(a_idle_clear, !sending, at_start, "idle with frame position set")
  `RLS_ASSERT_NXT(a_refresh_start, acc_refresh, sending && at_start && m_tdata[1], "no restart")
  `RLS_ASSERT_NXT(a_idle_tick, acc_tick && !sending, m_tvalid && !(|m_tdata[1:0]), "idle tick")
  `RLS_ASSERT_IMP(a_high_busy, m_tvalid && m_tdata[0], m_tdata[1] && !m_tdata[2], "stray high")

endmodule

@@ dv/rgb_led_string_serializer_test.sv @@
// ----------------------------------------------------------------------------
// RGB LED string serializer testbench
// Drives set color, refresh and tick items over the stream input and checks
// every line level, busy and ignored-write flag against an in-bench model of
// the frame waveform. Register settings change between traffic phases, from
// tight periods and empty frames to saturated LED counts and the widest
// values. The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module rgb_led_string_serializer_test;
  import rls_pkg::*;

  localparam int NUM_LEDS     = 16;
  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_ITEMS = 1900;
  localparam int RUN_LIMIT    = 6_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_LED_COUNT + 3'd1;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_CADENCE, RX_LONG} rx_mode_t;

  // frame waveform model plus the queue of line results still owed
  class led_frame_tracker;
    typedef struct packed {
      logic ignored;
      logic busy;
      logic level;
    } line_res_t;

    logic [TICK_W-1:0]  slot_len    = SLOT_LEN_RST;
    logic [TICK_W-1:0]  one_high    = ONE_HIGH_RST;
    logic [TICK_W-1:0]  zero_high   = ZERO_HIGH_RST;
    logic [RSLOT_W-1:0] reset_slots = RESET_SLOTS_RST;
    logic [LCNT_W-1:0]  led_count   = LED_COUNT_RST;
    logic [COLOR_W-1:0] colors [NUM_LEDS];
    logic [SLOT_W-1:0]  slot_idx = '0;
    logic [TICK_W-1:0]  tick_idx = '0;
    bit                 sending  = 1'b0;
    line_res_t          lines_due [$];
    int                 errors = 0;

    function new();
      foreach (colors[i]) colors[i] = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SLOT_LEN:    slot_len    = val[TICK_W-1:0];
        REG_ONE_HIGH:    one_high    = val[TICK_W-1:0];
        REG_ZERO_HIGH:   zero_high   = val[TICK_W-1:0];
        REG_RESET_SLOTS: reset_slots = val[RSLOT_W-1:0];
        REG_LED_COUNT:   led_count   = val[LCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int frame_len();
      int n;
      n = (led_count > NUM_LEDS) ? NUM_LEDS : led_count;
      return reset_slots + 24 * n;
    endfunction

    function logic [TICK_W-1:0] high_ticks(int slot);
      int b, led, pos;
      logic [COLOR_W-1:0] c;
      logic bitv;
      if (slot < reset_slots) return '0;
      b   = slot - reset_slots;
      led = b / 24;
      pos = b % 24;
      if (led >= NUM_LEDS) return '0;
      c = colors[led];
      // green, red, blue, each MSB first
      if (pos < 8) bitv = c[15 - pos];
      else if (pos < 16) bitv = c[23 - (pos - 8)];
      else bitv = c[7 - (pos - 16)];
      return bitv ? one_high : zero_high;
    endfunction

    function void accept_item(func_t f, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] col);
      line_res_t r;
      int total, period;
      r = '0;
      case (f)
        FUNC_SET: begin
          if (idx < NUM_LEDS) colors[idx] = col;
          else r.ignored = 1'b1;
          r.busy = sending;
        end
        FUNC_REFRESH: begin
          sending  = 1'b1;
          slot_idx = '0;
          tick_idx = '0;
          r.busy   = 1'b1;
        end
        default: begin
          if (sending) begin
            total = frame_len();
            if (slot_idx >= total) begin
              sending  = 1'b0;
              slot_idx = '0;
              tick_idx = '0;
            end else begin
              period   = (slot_len == 0) ? 1 : slot_len;
              r.level  = (tick_idx < high_ticks(slot_idx));
              r.busy   = 1'b1;
              tick_idx = tick_idx + 8'd1;
              if (tick_idx >= period) begin
                tick_idx = '0;
                slot_idx = slot_idx + 15'd1;
                if (slot_idx >= total) begin
                  sending  = 1'b0;
                  slot_idx = '0;
                end
              end
            end
          end
        end
      endcase
      lines_due.push_back(r);
    endfunction

    task check_line(logic [7:0] data);
      line_res_t e;
      if (lines_due.size() == 0) begin
        report($sformatf("result %02h with nothing expected", data));
        return;
      end
      e = lines_due.pop_front();
      if (data[0] !== e.level)
        report($sformatf("line_level %b, expected %b", data[0], e.level));
      if (data[1] !== e.busy)
        report($sformatf("busy_res %b, expected %b", data[1], e.busy));
      if (data[2] !== e.ignored)
        report($sformatf("write_ignored %b, expected %b", data[2], e.ignored));
    endtask

    function int waiting();
      return lines_due.size();
    endfunction

    task leftover_check();
      if (lines_due.size() != 0)
        report($sformatf("%0d results never arrived", lines_due.size()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // led_index[7:0], color[31:8]
  logic [1:0]            s_tuser;   // func[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [7:0]            m_tdata;   // line_level[0], busy_res[1], write_ignored[2]
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  led_frame_tracker tracker;

  int       items_sent = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       rx_phase   = 0;
  int       rx_stall   = 0;

  rgb_led_string_serializer #(.MAX_LEDS(NUM_LEDS)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("timeout");
    $display("** rgb_led_string_serializer: FAILED **");
    $finish;
  end

  // transfers and register writes as the block sees them
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_line(m_tdata);
      if (cfg_wen) tracker.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        tracker.accept_item(func_t'(s_tuser), s_tdata[7:0], s_tdata[31:8]);
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 9) > 2);
      RX_CADENCE: begin
        rx_phase = (rx_phase + 1) % 5;
        m_tready <= (rx_phase < 3);
      end
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall = $urandom_range(5, 20);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic pause(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tuser  <= 2'($urandom);
    s_tdata  <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(func_t f, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] col);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 7) != 0) pause($urandom_range(1, 8));
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {col, idx};
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // register value, now and then with stray bits above the register width
  function automatic logic [CFG_DATA_W-1:0] reg_value(int val, int width);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(val) & CFG_DATA_W'((1 << width) - 1);
    if (width < CFG_DATA_W && $urandom_range(0, 5) == 0)
      v = v | (CFG_DATA_W'($urandom) << width);
    return v;
  endfunction

  task automatic configure(int bp, int oh, int zh, int rs, int lc);
    wait_drained();
    write_reg(REG_SLOT_LEN, reg_value(bp, TICK_W));
    write_reg(REG_ONE_HIGH, reg_value(oh, TICK_W));
    write_reg(REG_ZERO_HIGH, reg_value(zh, TICK_W));
    write_reg(REG_RESET_SLOTS, reg_value(rs, RSLOT_W));
    write_reg(REG_LED_COUNT, reg_value(lc, LCNT_W));
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
  endtask

  function automatic int frame_ticks();
    return tracker.frame_len() * ((tracker.slot_len == 0) ? 1 : tracker.slot_len);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 7) == 0) return INDEX_W'($urandom_range(NUM_LEDS, 255));
    return INDEX_W'($urandom_range(0, NUM_LEDS - 1));
  endfunction

  task automatic noise_item();
    case ($urandom_range(0, 5))
      0:       send(FUNC_TICK_X, INDEX_W'($urandom), COLOR_W'($urandom));
      1:       send(FUNC_SET, pick_index(), pick_color());
      2:       send(FUNC_REFRESH, INDEX_W'($urandom), COLOR_W'($urandom));
      default: send(FUNC_TICK, INDEX_W'($urandom), COLOR_W'($urandom));
    endcase
  endtask

  // mostly whole frames: a few color writes, refresh, ticks to past the end
  task automatic traffic(int budget);
    int stop, n;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(0, 6) == 0) begin
        noise_item();
      end else begin
        repeat ($urandom_range(0, 3)) send(FUNC_SET, pick_index(), pick_color());
        if ($urandom_range(0, 15) == 0) wait_drained();
        send(FUNC_REFRESH, INDEX_W'($urandom), COLOR_W'($urandom));
        n = frame_ticks() + $urandom_range(0, 4);
        if (n > stop - items_sent) n = stop - items_sent;
        repeat (n)
          if ($urandom_range(0, 49) == 0) noise_item();
          else send(($urandom_range(0, 9) == 0) ? FUNC_TICK_X : FUNC_TICK,
                    INDEX_W'($urandom), COLOR_W'($urandom));
      end
    end
  endtask

  task automatic random_phase();
    int bp, oh, zh, rs, lc, ft, budget;
    bp = $urandom_range(2, 6);
    oh = $urandom_range(0, bp + 1);
    zh = $urandom_range(0, bp + 1);
    rs = $urandom_range(0, 3);
    lc = $urandom_range(1, 2);
    case ($urandom_range(0, 5))
      2: begin
        bp = $urandom_range(0, 1);
        oh = $urandom_range(0, 2);
        zh = $urandom_range(0, 2);
        lc = $urandom_range(1, 3);
      end
      3: lc = 0;
      4: begin
        bp = 1;
        oh = $urandom_range(0, 255);
        zh = $urandom_range(0, 255);
        lc = $urandom_range(NUM_LEDS, 2047);
      end
      5: begin
        bp = $urandom_range(2, 255);
        oh = $urandom_range(0, 255);
        zh = $urandom_range(0, 255);
        rs = $urandom_range(0, 1023);
        lc = $urandom_range(1, 1024);
      end
      default: ;
    endcase
    configure(bp, oh, zh, rs, lc);
    ft = frame_ticks();
    budget = (ft < 450) ? ft * $urandom_range(1, 3) + 40 : 80;
    if (budget > RANDOM_ITEMS + 25 - items_sent) budget = RANDOM_ITEMS + 25 - items_sent;
    traffic(budget);
  endtask

  initial begin
    tracker   = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = FUNC_TICK;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle ticks, store edges, out of range writes, restart mid frame
    send(FUNC_TICK, 8'h00, 24'h000000);
    send(FUNC_TICK_X, 8'hFF, 24'hFFFFFF);
    send(FUNC_SET, 8'd0, 24'hFFFFFF);
    send(FUNC_SET, INDEX_W'(NUM_LEDS - 1), 24'h000000);
    send(FUNC_SET, INDEX_W'(NUM_LEDS), 24'h123456);
    send(FUNC_SET, 8'hFF, 24'hFFFFFF);
    send(FUNC_REFRESH, 8'h00, 24'h000000);
    repeat (3) send(FUNC_TICK, 8'h00, 24'h000000);
    send(FUNC_SET, 8'd0, 24'h00FF00);
    send(FUNC_REFRESH, 8'hFF, 24'hFFFFFF);
    repeat (2) send(FUNC_TICK, 8'hAA, 24'h555555);
    send(FUNC_TICK_X, 8'h55, 24'hAAAAAA);
    send(FUNC_SET, 8'd1, 24'h5A5AA5);

    configure(2, 1, 0, 0, 1);
    traffic(120);
    configure(0, 1, 0, 2, 2);
    traffic(150);
    configure(1, 0, 255, 0, 1024);
    traffic(420);
    configure(255, 255, 254, 1023, 0);
    traffic(40);
    // shrinks the running frame to nothing
    configure(3, 2, 1, 0, 0);
    traffic(30);
    while (items_sent < RANDOM_ITEMS + 25) random_phase();

    wait_drained();
    repeat (8) @(posedge clk);
    tracker.leftover_check();
    if (tracker.errors == 0) begin
      $display("** rgb_led_string_serializer: PASSED **");
    end else begin
      $display("** rgb_led_string_serializer: FAILED **");
    end
    $finish;
  end
endmodule
